// ===== rtl/button_debounce_long_press_core_assert.svh =====
// Assertion macros used by the checker file of the button debounce core.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BDLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BDLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

// ===== rtl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce / long-press core.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int CNT_W     = 8;
  localparam int TIMER_W   = 16;
  localparam int ELAPSED_W = 10;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0]   INTEGRATOR_MAX_RST = 8'd8;
  localparam logic [TIMER_W-1:0] LONG_PRESS_MS_RST  = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATOR_MAX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 8'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_t;

  // Debounced level before and after the item being processed
  typedef struct packed {
    logic now_lvl;
    logic prev_lvl;
  } lvl_t;

endpackage

// ===== rtl/bdlp_integrator.sv =====
// Saturating integrator that turns raw samples into a debounced level.
`timescale 1ns / 1ps

module bdlp_integrator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    raw_level,
  input  logic [bdlp_pkg::CNT_W-1:0] integrator_max,
  output bdlp_pkg::lvl_t          lvl
);
  import bdlp_pkg::*;

  logic [CNT_W-1:0] count, count_next;
  logic             level, level_next;
  logic [CNT_W-1:0] stepped;

  always_comb begin
    if (!raw_level) begin
      stepped = (count != '0) ? count - 1'b1 : count;
    end else begin
      stepped = (count < integrator_max) ? count + 1'b1 : count;
    end
    count_next = stepped;
    level_next = level;
    if (stepped == '0) begin
      level_next = 1'b0;
    end else if (stepped >= integrator_max) begin
      count_next = integrator_max;
      level_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      level <= 1'b1;
    end else if (en) begin
      count <= count_next;
      level <= level_next;
    end
  end

  // stored level is the previous debounced level for the item in flight
  assign lvl.prev_lvl = level;
  assign lvl.now_lvl  = level_next;

endmodule

// ===== rtl/bdlp_press_tracker.sv =====
// Press / release / long-press event logic with the hold timer.
`timescale 1ns / 1ps

module bdlp_press_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bdlp_pkg::lvl_t                lvl,
  input  logic [bdlp_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  logic [bdlp_pkg::TIMER_W-1:0]  long_press_ms,
  output bdlp_pkg::ev_t                 ev
);
  import bdlp_pkg::*;

  logic               held, held_next;
  logic               long_rep, long_rep_next;
  logic [TIMER_W-1:0] timer, timer_next;
  logic [TIMER_W:0]   sum;
  logic               just_pressed;

  always_comb begin
    ev            = EV_NONE;
    held_next     = held;
    long_rep_next = long_rep;
    timer_next    = timer;
    just_pressed  = 1'b0;
    sum           = {1'b0, timer} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, elapsed_ms};

    if (!lvl.now_lvl && lvl.prev_lvl && !held) begin
      held_next    = 1'b1;
      timer_next   = '0;
      ev           = EV_PRESS;
      just_pressed = 1'b1;
    end

    if (!lvl.prev_lvl && lvl.now_lvl && held_next) begin
      if (!long_rep) begin
        ev = EV_RELEASE;
      end
      long_rep_next = 1'b0;
      timer_next    = '0;
      held_next     = 1'b0;
    end else if (held_next && !long_rep) begin
      if (!just_pressed) begin
        timer_next = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
      end
      if (timer_next >= long_press_ms) begin
        ev            = EV_LONG;
        long_rep_next = 1'b1;
        timer_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      long_rep <= 1'b0;
      timer    <= '0;
    end else if (en) begin
      held     <= held_next;
      long_rep <= long_rep_next;
      timer    <= timer_next;
    end
  end

endmodule

// ===== rtl/button_debounce_long_press_core.sv =====
// Top level of the button debounce core with press, release and long-press events.
//
// Usage:
//   s_* stream: one beat per raw button sample, tdata = {elapsed_ms, raw_level}.
//   m_* stream: exactly one beat per input beat, tdata = {debounced_level, event_code}.
//   cfg_* port: register writes (index 0 integrator_max, 1 long_press_ms), always
//     ready; write only while no sample is in flight.
// Pipeline: an accepted input beat goes into the input register and then into the
//   result register, where m_tvalid rises and the result beat waits to be taken.
//   Throughput: one beat per cycle while m_tready is high; the only loop is the
//   integrator / hold-timer state update between the two registers.
// Stall: when m_tready is low the result register holds, the input register
//   takes a beat only if it is empty, then s_tready drops until the result is taken.
// Reset: rst (sync, active high) empties both registers, clears the integrator
//   and the hold state, sets the debounced level to released (1) and reloads
//   integrator_max = 8 and long_press_ms = 1000.
// Events: 0 none, 1 press, 2 release, 3 long press (once per hold, and then no
//   release event for that hold).
`timescale 1ns / 1ps

module button_debounce_long_press_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [0] raw_level, [10:1] elapsed_ms
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [1:0] event_code, [2] debounced_level
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bdlp_pkg::*;

  // config registers
  logic [CNT_W-1:0]   integrator_max;
  logic [TIMER_W-1:0] long_press_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator_max <= INTEGRATOR_MAX_RST;
      long_press_ms  <= LONG_PRESS_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INTEGRATOR_MAX: integrator_max <= cfg_data[CNT_W-1:0];
        CFG_LONG_PRESS_MS:  long_press_ms  <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid;
  logic                 in_raw;
  logic [ELAPSED_W-1:0] in_elapsed;
  logic                 advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw     <= s_tdata[0];
      in_elapsed <= s_tdata[ELAPSED_W:1];
    end
  end

  // per-item state update
  lvl_t lvl;
  ev_t  ev;

  bdlp_integrator u_integrator (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .raw_level      (in_raw),
    .integrator_max (integrator_max),
    .lvl            (lvl)
  );

  bdlp_press_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .lvl           (lvl),
    .elapsed_ms    (in_elapsed),
    .long_press_ms (long_press_ms),
    .ev            (ev)
  );

  // result register
  logic [1:0] out_ev;
  logic       out_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev  <= ev;
      out_lvl <= lvl.now_lvl;
    end
  end

  assign m_tdata = {5'b0, out_lvl, out_ev};

endmodule

// ===== rtl/bdlp_checker.sv =====
// Port-level checker for the button debounce core, bound to the top level.
`timescale 1ns / 1ps
`include "button_debounce_long_press_core_assert.svh"

module bdlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);
  import bdlp_pkg::*;

  // held result beat stays put
  `BDLP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // with the result register empty the input side never stalls
  `BDLP_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

  // press and long press only come with a pressed level
  `BDLP_ASSERT_IMP(a_press_level,
    m_tvalid && (m_tdata[1:0] == EV_PRESS || m_tdata[1:0] == EV_LONG), !m_tdata[2])

  // release only comes with a released level
  `BDLP_ASSERT_IMP(a_release_level, m_tvalid && m_tdata[1:0] == EV_RELEASE, m_tdata[2])

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the button debounce and long-press core.
`timescale 1ns / 1ps

module tb;
  import bdlp_pkg::*;

  // Cycles with no accepted beat on any port before the run is called hung.
  // The worst honest gap is the longest source wait from draw_wait plus the longest
  // sink stall plus the two-stage pipe, so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;
  localparam int DIR_ROWS   = 9;
  localparam int N_PHASES   = 6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;   // [0] raw_level, [10:1] elapsed_ms
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // [1:0] event_code, [2] debounced_level
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  button_debounce_long_press_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Button model: integrator, debounced level, hold timer, long-press latch
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   integ_cnt;
  logic               level_now;
  logic               level_prev;
  logic               holding;
  logic               long_sent;
  logic [TIMER_W-1:0] hold_ms;
  logic [CNT_W-1:0]   integ_ceiling;
  logic [TIMER_W-1:0] long_press_limit;

  typedef struct {
    ev_t  ev;
    logic lvl;
  } report_t;

  // Reports owed by the core, oldest first
  report_t pending_reports[$];

  int err_cnt;
  int samples_sent;
  int settings_used;
  int press_seen, release_seen, long_seen, quiet_seen;
  int src_calm, snk_calm;

  task automatic reset_button_model();
    integ_cnt        = '0;
    level_now        = 1'b1;
    level_prev       = 1'b1;
    holding          = 1'b0;
    long_sent        = 1'b0;
    hold_ms          = '0;
    integ_ceiling    = INTEGRATOR_MAX_RST;
    long_press_limit = LONG_PRESS_MS_RST;
  endtask

  function automatic void debounce_step(input logic raw, input logic [ELAPSED_W-1:0] el,
                                        output ev_t ev, output logic lvl);
    logic              fresh;
    logic [TIMER_W:0]  sum;
    ev    = EV_NONE;
    fresh = 1'b0;
    // saturating integrator; pressed at zero, released at the ceiling
    if (!raw) begin
      if (integ_cnt != 0) integ_cnt--;
    end else if (integ_cnt < integ_ceiling) begin
      integ_cnt++;
    end
    if (integ_cnt == 0) begin
      level_now = 1'b0;
    end else if (integ_cnt >= integ_ceiling) begin
      integ_cnt = integ_ceiling;
      level_now = 1'b1;
    end
    // falling edge while released: press, timer restarts, this item adds nothing
    if (!level_now && level_prev && !holding) begin
      holding = 1'b1;
      hold_ms = '0;
      ev      = EV_PRESS;
      fresh   = 1'b1;
    end
    if (!level_prev && level_now && holding) begin
      // rising edge: release, silent if the long press already went out
      if (!long_sent) ev = EV_RELEASE;
      long_sent = 1'b0;
      hold_ms   = '0;
      holding   = 1'b0;
    end else if (holding && !long_sent) begin
      if (!fresh) begin
        sum     = {1'b0, hold_ms} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, el};
        hold_ms = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
      end
      if (hold_ms >= long_press_limit) begin
        ev        = EV_LONG;
        long_sent = 1'b1;
        hold_ms   = '0;
      end
    end
    level_prev = level_now;
    lvl        = level_now;
  endfunction

  // Wait draw shared by both sides: mostly a uniform random wait, with runs of back-to-back beats
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Elapsed time mix: zero, full scale, anything, short ticks.
  // Slow mode is nearly all full-scale steps so a hold can run the timer out.
  function automatic logic [ELAPSED_W-1:0] draw_elapsed(input bit slow);
    int pick;
    pick = $urandom_range(0, 7);
    if (slow && pick != 0) return {ELAPSED_W{1'b1}};
    case (pick)
      0: return '0;
      1: return {ELAPSED_W{1'b1}};
      2, 3, 4: return ELAPSED_W'($urandom_range(0, 1023));
      default: return ELAPSED_W'($urandom_range(0, 31));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sample source. Called at a clock edge; returns at the edge the beat went in.
  // A typed row supplies its own report; otherwise the model's is queued.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic raw, input logic [ELAPSED_W-1:0] el,
                             input bit typed, input ev_t typed_ev, input logic typed_lvl);
    int      gap;
    report_t rep;
    ev_t     p_ev;
    logic    p_lvl;
    gap = draw_wait(src_calm);
    // valid is only dropped when a gap follows, so back-to-back beats keep it high
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, el, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    debounce_step(raw, el, p_ev, p_lvl);
    rep.ev  = typed ? typed_ev : p_ev;
    rep.lvl = typed ? typed_lvl : p_lvl;
    pending_reports.push_back(rep);
    samples_sent++;
  endtask

  // Register write; leaves cfg_valid high so a second write can follow directly
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_INTEGRATOR_MAX) integ_ceiling = val[CNT_W-1:0];
    else if (idx == CFG_LONG_PRESS_MS) long_press_limit = val;
  endtask

  // New setting only once the pipe is empty: one report per sample, so an
  // empty queue means nothing is in flight
  task automatic apply_setting(input int ceil_val, input int limit_val);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    set_register(CFG_INTEGRATOR_MAX, CFG_DAT_W'(ceil_val));
    set_register(CFG_LONG_PRESS_MS, CFG_DAT_W'(limit_val));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  task automatic check_report(input logic [7:0] beat);
    report_t want;
    ev_t     got_ev;
    logic    got_lvl;
    got_ev  = ev_t'(beat[1:0]);
    got_lvl = beat[2];
    case (got_ev)
      EV_PRESS:   press_seen++;
      EV_RELEASE: release_seen++;
      EV_LONG:    long_seen++;
      default:    quiet_seen++;
    endcase
    if (pending_reports.size() == 0) begin
      $display("%0t: result beat with nothing outstanding: event %0d level %0b",
               $time, got_ev, got_lvl);
      err_cnt++;
    end else begin
      want = pending_reports.pop_front();
      if (got_ev !== want.ev) begin
        $display("%0t: event_code mismatch: expected %0d, got %0d", $time, want.ev, got_ev);
        err_cnt++;
      end
      if (got_lvl !== want.lvl) begin
        $display("%0t: debounced_level mismatch: expected %0b, got %0b",
                 $time, want.lvl, got_lvl);
        err_cnt++;
      end
    end
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(snk_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_report(m_tdata);
    end
  end

  // Hang detector: counts edges at which no port moved a beat
  int quiet_edges = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_edges = 0;
    end else begin
      quiet_edges++;
      if (quiet_edges == HANG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, run on reset values (ceiling 8, long press 1000 ms).
  // Typed rows carry an obvious report; the rest go through the model.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic                 raw;
    logic [ELAPSED_W-1:0] el;
    int                   reps;
    bit                   typed;
    ev_t                  ev;
    logic                 lvl;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // count is zero out of reset, so the first low sample is already a press
    '{1'b0, 10'd1023, 1, 1'b1, EV_PRESS, 1'b0},
    // full-scale step crosses 1000 ms at once
    '{1'b0, 10'd1023, 1, 1'b1, EV_LONG,  1'b0},
    // climb back to the ceiling; release after a long press is silent
    '{1'b1, 10'd0,    7, 1'b0, EV_NONE,  1'b1},
    '{1'b1, 10'd1023, 1, 1'b0, EV_NONE,  1'b1},
    // fresh press: elapsed on the press beat itself is ignored
    '{1'b0, 10'd17,   7, 1'b0, EV_NONE,  1'b1},
    '{1'b0, 10'd1023, 1, 1'b0, EV_NONE,  1'b1},
    // hold to 999 ms, one short of the limit, then a plain release
    '{1'b0, 10'd998,  1, 1'b0, EV_NONE,  1'b1},
    '{1'b1, 10'd1,    1, 1'b0, EV_NONE,  1'b1},
    '{1'b1, 10'd0,    7, 1'b0, EV_NONE,  1'b1}
  };

  // Settings, in order. Ceiling 8 -> 1 clamps a full count down; ceiling 0
  // pins the level low; the 255 / 65535 setting is entered released with a
  // low count so one long hold in slow mode saturates the timer.
  int  ph_ceil  [N_PHASES] = '{1, 0, 3, 255, 0, 8};
  int  ph_limit [N_PHASES] = '{0, 1, 40, 65535, 0, 1000};
  int  ph_items [N_PHASES] = '{80, 40, 150, 170, 150, 110};
  bit  ph_slow  [N_PHASES] = '{0, 0, 0, 1, 0, 0};

  initial begin
    int   p, i, r;
    int   ceil_v, run_left;
    bit   first_run;
    logic run_lvl, raw;
    int   dir_count;
    err_cnt = 0;
    samples_sent = 0;
    settings_used = 1;
    press_seen = 0;
    release_seen = 0;
    long_seen = 0;
    quiet_seen = 0;
    src_calm = 0;
    snk_calm = 0;
    ph_ceil[4]  = $urandom_range(1, 12);
    ph_limit[4] = $urandom_range(1, 4000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    reset_button_model();

    for (r = 0; r < DIR_ROWS; r++) begin
      for (i = 0; i < dir_rows[r].reps; i++) begin
        send_sample(dir_rows[r].raw, dir_rows[r].el, dir_rows[r].typed,
                    dir_rows[r].ev, dir_rows[r].lvl);
      end
    end
    dir_count = samples_sent;

    for (p = 0; p < N_PHASES; p++) begin
      apply_setting(ph_ceil[p], ph_limit[p]);
      ceil_v    = ph_ceil[p];
      run_lvl   = 1'b1;
      run_left  = 0;
      first_run = 1'b1;
      // Alternating runs long enough to switch the level, with one in four cut
      // short (aborted transitions) and one sample in ten flipped as bounce.
      for (i = 0; i < ph_items[p]; i++) begin
        if (run_left == 0) begin
          run_lvl = ~run_lvl;
          if (!first_run && $urandom_range(0, 3) == 0)
            run_left = $urandom_range(1, ceil_v / 2 + 1);
          else
            run_left = $urandom_range(ceil_v + 1, 2 * ceil_v + 3);
          first_run = 1'b0;
        end
        run_left--;
        raw = run_lvl ^ ($urandom_range(0, 9) == 0);
        send_sample(raw, draw_elapsed(ph_slow[p]), 1'b0, EV_NONE, 1'b1);
      end
      // small ceilings: finish with high samples so the next setting starts released (a ceiling of 0 stays low)
      if (ceil_v <= 16) begin
        for (i = 0; i <= ceil_v; i++) begin
          send_sample(1'b1, draw_elapsed(1'b0), 1'b0, EV_NONE, 1'b1);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // catch any stray extra beats
    repeat (30) @(posedge clk);

    $display("covered %0d samples (%0d from the table) over %0d register settings",
             samples_sent, dir_count, settings_used);
    $display("events seen: %0d press, %0d release, %0d long press, %0d none",
             press_seen, release_seen, long_seen, quiet_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
